// File: design/shbe_pkg.sv
// Package for the string hash bucket engine: codes, states, start values and fold helpers.
package shbe_pkg;

    // Hash, byte, modulo, configuration and step widths
    localparam int unsigned HASH_W   = 64;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned BUCKET_W = 31;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned STEP_W   = 3;

    // Mode start values
    localparam logic [HASH_W-1:0] DJB2_START = 64'd5381;
    localparam logic [HASH_W-1:0] FNV_START  = 64'd2166136261;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 2'd1;

    typedef enum logic [2:0] {
        MODE_DJB2        = 3'd0,
        MODE_FNV1A       = 3'd1,
        MODE_SHIFT_XOR   = 3'd2,
        MODE_ROTATE_XOR  = 3'd3,
        MODE_ADDITIVE    = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FOLD,
        ST_MOD,
        ST_EMIT
    } t_state;

    // Map a written mode code; unused codes behave as djb2
    function automatic t_mode decode_mode(input logic [2:0] code);
        t_mode m;
        if (code > MODE_ADDITIVE) begin
            m = MODE_DJB2;
        end else begin
            m = t_mode'(code);
        end
        return m;
    endfunction

    function automatic logic [HASH_W-1:0] start_value(input t_mode mode);
        logic [HASH_W-1:0] v;
        case (mode)
            MODE_DJB2:  v = DJB2_START;
            MODE_FNV1A: v = FNV_START;
            default:    v = '0;
        endcase
        return v;
    endfunction

    // Accumulator load value when a byte arrives (rotate-xor is complete here)
    function automatic logic [HASH_W-1:0] fold_init(input t_mode mode,
                                                    input logic [HASH_W-1:0] h,
                                                    input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] v;
        logic [HASH_W-1:0] bx;
        bx = {{(HASH_W-BYTE_W){1'b0}}, b};
        case (mode)
            MODE_FNV1A:      v = h ^ bx;
            MODE_SHIFT_XOR:  v = h << 5;
            MODE_ROTATE_XOR: v = (h << 4) ^ (h >> 28) ^ bx;
            MODE_ADDITIVE:   v = h;
            default:         v = h << 5;
        endcase
        return v;
    endfunction

    // Addend for each step of the shared adder.
    // The FNV prime is 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1, so the product is a
    // sum of shifted copies of x = h ^ b, the unshifted copy being the load.
    function automatic logic [HASH_W-1:0] fold_operand(input t_mode mode,
                                                       input logic [STEP_W-1:0] step,
                                                       input logic [HASH_W-1:0] h,
                                                       input logic [HASH_W-1:0] x,
                                                       input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] v;
        logic [HASH_W-1:0] bx;
        bx = {{(HASH_W-BYTE_W){1'b0}}, b};
        v  = bx;
        case (mode)
            MODE_FNV1A: begin
                case (step)
                    3'd0:    v = x << 1;
                    3'd1:    v = x << 4;
                    3'd2:    v = x << 7;
                    3'd3:    v = x << 8;
                    default: v = x << 24;
                endcase
            end
            MODE_SHIFT_XOR: begin
                v = (step == '0) ? (h >> 2) : bx;
            end
            MODE_ADDITIVE: begin
                v = bx;
            end
            default: begin
                v = (step == '0) ? h : bx;
            end
        endcase
        return v;
    endfunction

    // Index of the last adder step for each mode
    function automatic logic [STEP_W-1:0] fold_last(input t_mode mode);
        logic [STEP_W-1:0] v;
        case (mode)
            MODE_FNV1A:    v = 3'd4;
            MODE_ADDITIVE: v = 3'd0;
            default:       v = 3'd1;
        endcase
        return v;
    endfunction

endpackage

// File: design/shbe_mod_unit.sv
// Restoring 64-by-31-bit remainder unit, one dividend bit per cycle.
module shbe_mod_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [shbe_pkg::HASH_W-1:0]        i_dividend,
    input  logic [shbe_pkg::BUCKET_W-1:0]      i_divisor,
    output logic                               o_done,
    output logic [shbe_pkg::BUCKET_W-1:0]      o_remainder
);

    localparam int unsigned CNT_W = $clog2(shbe_pkg::HASH_W);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(shbe_pkg::HASH_W - 1);

    logic                               r_busy;
    logic                               r_done;
    logic [CNT_W-1:0]                   r_count;
    logic [shbe_pkg::HASH_W-1:0]        r_quo;
    logic [shbe_pkg::BUCKET_W-1:0]      r_div;
    logic [shbe_pkg::BUCKET_W-1:0]      r_rem;
    logic [shbe_pkg::BUCKET_W-1:0]      n_rem;
    logic [shbe_pkg::BUCKET_W:0]        trial;
    logic [shbe_pkg::BUCKET_W:0]        diff;

    // Shift in the next dividend bit, subtract the divisor when it fits
    always_comb begin
        trial = {r_rem, r_quo[shbe_pkg::HASH_W-1]};
        diff  = trial - {1'b0, r_div};
        if (trial >= {1'b0, r_div}) begin
            n_rem = diff[shbe_pkg::BUCKET_W-1:0];
        end else begin
            n_rem = trial[shbe_pkg::BUCKET_W-1:0];
        end
    end

    // Control: busy flag, step count, done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + 1'b1;
                if (r_count == LAST_CNT) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: latch operands, then iterate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= r_quo << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

// File: design/string_hash_bucket_engine.sv
// Top level of the string hash bucket engine: key byte folding and bucket selection.
//
//  channel   direction  valid        ready        payload
//  -------   ---------  -----        -----        -------
//  key in    input      i_valid      o_ready      i_key_byte, i_no_key
//  bucket    output     o_valid      i_ready      o_bucket_index
//  config    input      i_cfg_valid  o_cfg_ready  i_cfg_index, i_cfg_data
//
// A nonzero key byte is folded by fold_init alone in rotate-xor mode; in the other modes
// one 64-bit adder accumulates one term per cycle. A terminating zero byte hands the
// hash to the remainder unit, which retires one dividend bit per cycle. A null key or
// a zero bucket count skips the remainder unit.
// Reset is synchronous; it restores djb2 mode, one bucket and the djb2 start value.
// A result held at the output does not stall byte folding; only the next result waits.
module string_hash_bucket_engine (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [shbe_pkg::BYTE_W-1:0]          i_key_byte,
    input  logic                                 i_no_key,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [shbe_pkg::BUCKET_W-1:0]        o_bucket_index,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [shbe_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [shbe_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    shbe_pkg::t_state                   r_state, n_state;
    shbe_pkg::t_mode                    r_mode, n_mode;
    logic [shbe_pkg::BUCKET_W-1:0]      r_bucket_count, n_bucket_count;
    logic [shbe_pkg::HASH_W-1:0]        r_hash, n_hash;
    logic [shbe_pkg::HASH_W-1:0]        r_acc, n_acc;
    logic [shbe_pkg::HASH_W-1:0]        r_x, n_x;
    logic [shbe_pkg::BYTE_W-1:0]        r_byte, n_byte;
    logic [shbe_pkg::STEP_W-1:0]        r_step, n_step;
    logic [shbe_pkg::BUCKET_W-1:0]      r_result, n_result;
    logic                               r_out_valid, n_out_valid;
    logic [shbe_pkg::BUCKET_W-1:0]      r_bucket_index, n_bucket_index;

    logic                               in_fire;
    logic                               cfg_fire;
    logic [shbe_pkg::HASH_W-1:0]        fold_sum;
    logic                               mod_start;
    logic                               mod_done;
    logic [shbe_pkg::BUCKET_W-1:0]      mod_rem;
    shbe_pkg::t_mode                    cfg_mode;

    assign o_ready     = (r_state == shbe_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_valid && o_ready;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;
    assign cfg_mode    = shbe_pkg::decode_mode(i_cfg_data[2:0]);

    // Shared adder for all folding steps
    assign fold_sum = r_acc + shbe_pkg::fold_operand(r_mode, r_step, r_hash, r_x, r_byte);

    shbe_mod_unit u_mod (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (mod_start),
        .i_dividend  (r_hash),
        .i_divisor   (r_bucket_count),
        .o_done      (mod_done),
        .o_remainder (mod_rem)
    );

    // Sequencer: next state, datapath updates and output slot
    always_comb begin
        n_state        = r_state;
        n_mode         = r_mode;
        n_bucket_count = r_bucket_count;
        n_hash         = r_hash;
        n_acc          = r_acc;
        n_x            = r_x;
        n_byte         = r_byte;
        n_step         = r_step;
        n_result       = r_result;
        n_out_valid    = r_out_valid;
        n_bucket_index = r_bucket_index;
        mod_start      = 1'b0;

        // Drop a delivered result
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            shbe_pkg::ST_IDLE: begin
                if (in_fire) begin
                    if (i_no_key) begin
                        n_result = '0;
                        n_hash   = shbe_pkg::start_value(r_mode);
                        n_state  = shbe_pkg::ST_EMIT;
                    end else if (i_key_byte != '0) begin
                        n_acc  = shbe_pkg::fold_init(r_mode, r_hash, i_key_byte);
                        n_x    = r_hash ^ {{(shbe_pkg::HASH_W-shbe_pkg::BYTE_W){1'b0}},
                                           i_key_byte};
                        n_byte = i_key_byte;
                        n_step = '0;
                        if (r_mode == shbe_pkg::MODE_ROTATE_XOR) begin
                            n_hash = n_acc;
                        end else begin
                            n_state = shbe_pkg::ST_FOLD;
                        end
                    end else if (r_bucket_count == '0) begin
                        n_result = '0;
                        n_hash   = shbe_pkg::start_value(r_mode);
                        n_state  = shbe_pkg::ST_EMIT;
                    end else begin
                        // Hand the finished hash to the remainder unit, then restart
                        mod_start = 1'b1;
                        n_hash    = shbe_pkg::start_value(r_mode);
                        n_state   = shbe_pkg::ST_MOD;
                    end
                end
            end
            shbe_pkg::ST_FOLD: begin
                n_acc  = fold_sum;
                n_step = r_step + 1'b1;
                if (r_step == shbe_pkg::fold_last(r_mode)) begin
                    if (r_mode == shbe_pkg::MODE_SHIFT_XOR) begin
                        n_hash = r_hash ^ fold_sum;
                    end else begin
                        n_hash = fold_sum;
                    end
                    n_state = shbe_pkg::ST_IDLE;
                end
            end
            shbe_pkg::ST_MOD: begin
                if (mod_done) begin
                    n_result = mod_rem;
                    n_state  = shbe_pkg::ST_EMIT;
                end
            end
            shbe_pkg::ST_EMIT: begin
                // Load the output slot once it is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid    = 1'b1;
                    n_bucket_index = r_result;
                    n_state        = shbe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = shbe_pkg::ST_IDLE;
            end
        endcase

        // Configuration writes must arrive only while idle; the block itself does not enforce this
        if (cfg_fire) begin
            case (i_cfg_index)
                shbe_pkg::CFG_HASH_MODE: begin
                    n_mode = cfg_mode;
                    n_hash = shbe_pkg::start_value(cfg_mode);
                end
                shbe_pkg::CFG_BUCKET_COUNT: begin
                    n_bucket_count = i_cfg_data[shbe_pkg::BUCKET_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= shbe_pkg::ST_IDLE;
            r_mode         <= shbe_pkg::MODE_DJB2;
            r_bucket_count <= {{(shbe_pkg::BUCKET_W-1){1'b0}}, 1'b1};
            r_hash         <= shbe_pkg::DJB2_START;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_mode         <= n_mode;
            r_bucket_count <= n_bucket_count;
            r_hash         <= n_hash;
            r_out_valid    <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_acc          <= n_acc;
        r_x            <= n_x;
        r_byte         <= n_byte;
        r_step         <= n_step;
        r_result       <= n_result;
        r_bucket_index <= n_bucket_index;
    end

    assign o_valid        = r_out_valid;
    assign o_bucket_index = r_bucket_index;

endmodule

// File: design/shbe_checker.sv
// Port-level checker for the string hash bucket engine, bound to the top level.
module shbe_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 o_ready,
    input  logic [shbe_pkg::BYTE_W-1:0]          i_key_byte,
    input  logic                                 i_no_key,
    input  logic                                 o_valid,
    input  logic                                 i_ready,
    input  logic [shbe_pkg::BUCKET_W-1:0]        o_bucket_index,
    input  logic                                 i_cfg_valid,
    input  logic                                 o_cfg_ready
);

    logic in_fire;
    logic ends_key;

    assign in_fire  = i_valid && o_ready;
    assign ends_key = i_no_key || (i_key_byte == '0);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_bucket_index))
        else $error("stalled result changed or dropped");

    // Clear the result slot on reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A byte inside a key gives no result right away
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && !ends_key |=> !$rose(o_valid))
        else $error("result raised for a key byte");

    // A finished key keeps the input stalled while its index is formed
    a_busy_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && ends_key |=> !o_ready)
        else $error("input ready right after end of key");

    // Config writes are always taken
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write refused");

endmodule

bind string_hash_bucket_engine shbe_checker u_shbe_checker (.*);

// File: dv/string_hash_bucket_engine_checker.sv
// Bucket index checker: tracks configuration and key bytes, predicts and compares each index.
`timescale 1ns / 100ps

module string_hash_bucket_engine_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_key_valid,
    input  logic                                 i_key_ready,
    input  logic [shbe_pkg::BYTE_W-1:0]          i_key_byte,
    input  logic                                 i_no_key,
    input  logic                                 i_bucket_valid,
    input  logic                                 i_bucket_ready,
    input  logic [shbe_pkg::BUCKET_W-1:0]        i_bucket_index,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [shbe_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [shbe_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import shbe_pkg::*;

    localparam logic [HASH_W-1:0] DJB2_SEED = 64'd5381;
    localparam logic [HASH_W-1:0] FNV_SEED  = 64'd2166136261;
    localparam logic [HASH_W-1:0] FNV_MULT  = 64'd16777619;

    t_mode                 hash_mode_q;
    logic [HASH_W-1:0]     hash_acc;
    logic [BUCKET_W-1:0]   bucket_total;
    logic [BUCKET_W-1:0]   index_fifo[$];
    int                    fails = 0;

    assign o_fail_count = fails;

    function automatic logic [HASH_W-1:0] mode_seed(input t_mode m);
        logic [HASH_W-1:0] s;
        case (m)
            MODE_FNV1A: s = FNV_SEED;
            MODE_DJB2:  s = DJB2_SEED;
            default:    s = '0;
        endcase
        return s;
    endfunction

    // Fold one key byte into the running hash, wrapping at 64 bits
    function automatic logic [HASH_W-1:0] fold_key_byte(input t_mode m,
                                                        input logic [HASH_W-1:0] h,
                                                        input logic [BYTE_W-1:0] b);
        logic [HASH_W-1:0] bx;
        logic [HASH_W-1:0] nh;
        bx = HASH_W'(b);
        case (m)
            MODE_FNV1A:      nh = (h ^ bx) * FNV_MULT;
            MODE_SHIFT_XOR:  nh = h ^ ((h << 5) + (h >> 2) + bx);
            MODE_ROTATE_XOR: nh = (h << 4) ^ (h >> 28) ^ bx;
            MODE_ADDITIVE:   nh = h + bx;
            default:         nh = (h << 5) + h + bx;
        endcase
        return nh;
    endfunction

    function automatic logic [BUCKET_W-1:0] bucket_of(input logic [HASH_W-1:0] h,
                                                      input logic [BUCKET_W-1:0] total);
        logic [HASH_W-1:0] rem;
        if (total == '0) begin
            rem = '0;
        end else begin
            rem = h % HASH_W'(total);
        end
        return BUCKET_W'(rem);
    endfunction

    always @(posedge i_clk) begin : predict
        logic [BUCKET_W-1:0] want;
        logic [2:0]          code;
        if (!i_rst_n) begin
            hash_mode_q  = MODE_DJB2;
            bucket_total = BUCKET_W'(1);
            hash_acc     = DJB2_SEED;
            index_fifo.delete();
        end else begin
            // Compare each bucket transaction with the oldest prediction
            if (i_bucket_valid && i_bucket_ready) begin
                if (index_fifo.size() == 0) begin
                    $display("%0t: unexpected bucket index %0d, none expected",
                             $time, i_bucket_index);
                    fails++;
                end else begin
                    want = index_fifo.pop_front();
                    if (i_bucket_index !== want) begin
                        $display("%0t: bucket index mismatch, expected %0d actual %0d",
                                 $time, want, i_bucket_index);
                        fails++;
                    end
                end
            end

            // Apply register writes; a mode write restarts the key
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HASH_MODE: begin
                        code        = i_cfg_data[2:0];
                        hash_mode_q = (code > MODE_ADDITIVE) ? MODE_DJB2 : t_mode'(code);
                        hash_acc    = mode_seed(hash_mode_q);
                    end
                    CFG_BUCKET_COUNT: begin
                        bucket_total = i_cfg_data[BUCKET_W-1:0];
                    end
                    default: begin
                        // drop writes to unused indexes
                    end
                endcase
            end

            // Fold key bytes; a terminator or a missing key yields one index
            if (i_key_valid && i_key_ready) begin
                if (i_no_key) begin
                    index_fifo.push_back('0);
                    hash_acc = mode_seed(hash_mode_q);
                end else if (i_key_byte != '0) begin
                    hash_acc = fold_key_byte(hash_mode_q, hash_acc, i_key_byte);
                end else begin
                    index_fifo.push_back(bucket_of(hash_acc, bucket_total));
                    hash_acc = mode_seed(hash_mode_q);
                end
            end
        end
        o_pending <= index_fifo.size();
    end

endmodule

// File: dv/string_hash_bucket_engine_test.sv
// Testbench top for the string hash bucket engine: stimulus, receiver stalls and verdict.
`timescale 1ns / 100ps

module string_hash_bucket_engine_test;
    import shbe_pkg::*;

    localparam int RESET_CYCLES    = 10;
    localparam int CYCLE_LIMIT     = 500000;
    localparam int LONG_HOLD       = 300;
    localparam int IDLE_SETTLE     = 16;
    localparam int DRAIN_CYCLES    = 100;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 52;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [BYTE_W-1:0]    KEY_END     = 8'h00;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [BYTE_W-1:0]      i_key_byte;
    logic                   i_no_key;
    logic                   o_valid;
    logic                   i_ready;
    logic [BUCKET_W-1:0]    o_bucket_index;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int fail_count;
    int pending;
    bit quiet_src   = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_served = 1'b0;

    string_hash_bucket_engine uut (
        .i_clk,
        .i_rst_n,
        .i_valid,
        .o_ready,
        .i_key_byte,
        .i_no_key,
        .o_valid,
        .i_ready,
        .o_bucket_index,
        .i_cfg_valid,
        .o_cfg_ready,
        .i_cfg_index,
        .i_cfg_data
    );

    string_hash_bucket_engine_checker bucket_check (
        .i_clk,
        .i_rst_n,
        .i_key_valid    (i_valid),
        .i_key_ready    (o_ready),
        .i_key_byte,
        .i_no_key,
        .i_bucket_valid (o_valid),
        .i_bucket_ready (i_ready),
        .i_bucket_index (o_bucket_index),
        .i_cfg_valid,
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index,
        .i_cfg_data,
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Mostly no gap, some short, a few long
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [BYTE_W-1:0] pick_key_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 8'hFF;
        if (r == 1) return 8'h01;
        return BYTE_W'($urandom_range(1, 255));
    endfunction

    // Offer one key transaction after a random gap and hold it until accepted
    task automatic send_key_byte(input logic [BYTE_W-1:0] b, input logic nk);
        int gap;
        gap = pick_gap(quiet_src);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_key_byte <= b;
        i_no_key   <= nk;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Send a key of random bytes, usually closed by a terminator, sometimes by a null key
    task automatic send_key(input int len, inout int sent);
        for (int k = 0; k < len; k++) begin
            send_key_byte(pick_key_byte(), 1'b0);
        end
        if ($urandom_range(0, 9) == 0) begin
            send_key_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
        end else begin
            send_key_byte(KEY_END, 1'b0);
        end
        sent += len + 1;
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Wait for the block to go idle, then write the requested registers
    task automatic apply_settings(input bit wr_mode, input logic [2:0] code,
                                  input bit wr_count, input logic [BUCKET_W-1:0] total,
                                  input bit wr_spare);
        i_valid <= 1'b0;
        wait_drained();
        repeat (IDLE_SETTLE) @(posedge i_clk);
        if (wr_mode) begin
            cfg_put(CFG_HASH_MODE, ($urandom() & ~32'h7) | CFG_DATA_W'(code));
        end
        if (wr_count) begin
            cfg_put(CFG_BUCKET_COUNT, {1'($urandom_range(0, 1)), total});
        end
        if (wr_spare) begin
            cfg_put(($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B, $urandom());
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Receiver: random stalls, long ready runs, and one long hold-off on request
    initial begin : sink
        int run;
        int gap;
        i_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_req && !hold_served) begin
                hold_served = 1'b1;
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            gap = pick_gap(1'b0);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            run = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 6);
            i_ready <= 1'b1;
            repeat (run) @(posedge i_clk);
        end
    end

    // End a hung run
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin : stimulus
        int               sent;
        int               len;
        logic [2:0]       code;
        logic [BUCKET_W-1:0] total;

        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_key_byte  <= '0;
        i_no_key    <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sent = 0;

        // Empty key under reset settings
        send_key_byte(KEY_END, 1'b0);

        // Widest bucket count, extreme bytes, null keys with and without a byte
        apply_settings(1'b1, MODE_DJB2, 1'b1, 31'h7FFF_FFFF, 1'b1);
        send_key_byte(8'h61, 1'b0);
        send_key_byte(8'h62, 1'b0);
        send_key_byte(KEY_END, 1'b0);
        send_key_byte(8'hFF, 1'b0);
        send_key_byte(8'h01, 1'b0);
        send_key_byte(8'h80, 1'b0);
        send_key_byte(KEY_END, 1'b0);
        send_key_byte(8'hA5, 1'b1);
        send_key_byte(KEY_END, 1'b1);

        // Null key in the middle of a key abandons it
        send_key_byte(8'h41, 1'b0);
        send_key_byte(8'h42, 1'b0);
        send_key_byte(8'h7E, 1'b1);
        send_key_byte(KEY_END, 1'b0);

        // Zero bucket count
        apply_settings(1'b1, MODE_FNV1A, 1'b1, '0, 1'b0);
        send_key_byte(8'h7F, 1'b0);
        send_key_byte(KEY_END, 1'b0);

        // Bucket count change keeps a partial key
        apply_settings(1'b1, MODE_ADDITIVE, 1'b1, 31'd7, 1'b0);
        send_key_byte(8'h10, 1'b0);
        apply_settings(1'b0, MODE_ADDITIVE, 1'b1, 31'd3, 1'b0);
        send_key_byte(8'h21, 1'b0);
        send_key_byte(KEY_END, 1'b0);

        // Mode change drops a partial key
        send_key_byte(8'h33, 1'b0);
        apply_settings(1'b1, MODE_ROTATE_XOR, 1'b1, 31'd1000, 1'b1);
        send_key_byte(8'h55, 1'b0);
        send_key_byte(KEY_END, 1'b0);

        // Hold the receiver off while results pile up and the input stalls
        apply_settings(1'b1, MODE_SHIFT_XOR, 1'b1, 31'd97, 1'b0);
        hold_req = 1'b1;
        while (!hold_served) @(posedge i_clk);
        repeat (8) send_key_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
        repeat (3) begin
            send_key_byte(pick_key_byte(), 1'b0);
            send_key_byte(KEY_END, 1'b0);
        end

        // Random keys under a sweep of modes and bucket counts
        for (int phase = 0; phase < PHASES; phase++) begin
            code = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
            case (phase % 5)
                0:       total = 31'h7FFF_FFFF;
                1:       total = BUCKET_W'($urandom_range(1, 64));
                2:       total = BUCKET_W'($urandom());
                3:       total = BUCKET_W'(1) << $urandom_range(0, 30);
                default: total = (phase == 4) ? '0 : BUCKET_W'(1);
            endcase
            apply_settings(phase != PHASES - 1, code, 1'b1, total, (phase % 2) != 0);
            quiet_src = (phase % 4) == 3;
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 99) < 8) begin
                    send_key_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
                    sent++;
                end else begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40)
                                                     : $urandom_range(0, 8);
                    send_key(len, sent);
                end
            end
        end

        // Drain and report
        i_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/shbe_pkg.sv
design/shbe_mod_unit.sv
design/string_hash_bucket_engine.sv
design/shbe_checker.sv
dv/string_hash_bucket_engine_checker.sv
dv/string_hash_bucket_engine_test.sv
